### rtl/bpp_pkg.sv
// shared types and constants for the boris particle push block
package bpp_pkg;

   // time step after reset, about 0.1 in unsigned q15.16
   localparam logic [30:0] TimeStepReset = 31'd6554;

   // rotation divider: numerator, divisor and quotient widths
   localparam int NumW = 51;
   localparam int DenW = 50;
   localparam int QuoW = 18;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [31:0] efield_x;
      logic signed [31:0] efield_y;
      logic signed [31:0] efield_z;
      logic signed [31:0] bfield_x;
      logic signed [31:0] bfield_y;
      logic signed [31:0] bfield_z;
   } bpp_req_type;

   typedef struct packed {
      logic signed [31:0] new_pos_x;
      logic signed [31:0] new_pos_y;
      logic signed [31:0] new_pos_z;
      logic signed [31:0] new_vel_x;
      logic signed [31:0] new_vel_y;
      logic signed [31:0] new_vel_z;
   } bpp_rsp_type;

endpackage

### rtl/bpp_div.sv
// pipelined restoring divider, one quotient bit per stage
module bpp_div import bpp_pkg::*; (
   input  logic            clock,
   input  logic [NumW-1:0] num,
   input  logic [DenW-1:0] den,
   output logic [QuoW-1:0] quo
);

   typedef struct packed {
      logic [NumW-1:0] rem;
      logic [DenW-1:0] den;
      logic [QuoW-1:0] quo;
   } div_stage_type;

   div_stage_type stage_ff [QuoW];
   div_stage_type stage_in [QuoW];
   div_stage_type first;

   function automatic div_stage_type div_step(div_stage_type s, int unsigned bitpos);
      div_stage_type r;
      logic [NumW-1:0] shifted;
      r = s;
      shifted = s.rem >> bitpos;
      if (shifted >= NumW'(s.den)) begin
         r.rem = s.rem - (NumW'(s.den) << bitpos);
         r.quo = s.quo | (QuoW'(1) << bitpos);
      end
      return r;
   endfunction

   assign first = '{rem: num, den: den, quo: '0};

   always_comb begin
      stage_in[0] = div_step(first, QuoW - 1);
      for (int i = 1; i < QuoW; i++) begin
         stage_in[i] = div_step(stage_ff[i-1], QuoW - 1 - i);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QuoW; i++) begin
         stage_ff[i] <= stage_in[i];
      end
   end

   assign quo = stage_ff[QuoW-1].quo;

endmodule

### rtl/boris_particle_push_top.sv
// top level of the boris particle push pipeline
//
//  channel  ports                    width       direction  flow control
//  req      start busy req_data      12 x 32     in         start && !busy
//  rsp      rsp_valid rsp_data       6 x 32      out        one-cycle strobe, no stall
//  csr      csr_we csr_wdata         31          in         write on csr_we
//
// one particle per cycle sustained, 10 arithmetic stages (a to j) plus 18 stages of
// the bit-per-stage rotation divider
// busy is never raised: the receiver cannot stall, so nothing ever backs up
// synchronous reset clears the valid line and loads the default time step
// the time step register feeds stages a and i; the user must write it only while empty
module boris_particle_push_top import bpp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  bpp_req_type req_data,
   output logic        rsp_valid,
   output bpp_rsp_type rsp_data,
   input  logic        csr_we,
   input  logic [30:0] csr_wdata
);

   localparam int Lat = 10 + QuoW;

   // wide signed multiply, operands already extended
   function automatic logic signed [63:0] smul(logic signed [63:0] a, logic signed [63:0] b);
      return a * b;
   endfunction

   // product times dt/2, round half up
   function automatic logic signed [47:0] rh(logic signed [63:0] p);
      logic signed [63:0] r;
      r = (p + 64'sd65536) >>> 17;
      return r[47:0];
   endfunction

   // q16.16 product, round half up
   function automatic logic signed [47:0] rm(logic signed [63:0] p);
      logic signed [63:0] r;
      r = (p + 64'sd32768) >>> 16;
      return r[47:0];
   endfunction

   function automatic logic signed [31:0] sat32(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   typedef struct packed {
      logic [2:0][31:0] vq;
      logic [2:0][31:0] vm;
      logic [2:0][31:0] p1;
      logic [2:0][47:0] ek;
      logic [2:0]       tneg;
   } side_type;

   // control
   logic            accept;
   logic [30:0]     time_step_ff;
   logic [Lat-1:0]  vld_ff;
   logic [Lat-1:0]  vld_in;
   logic signed [63:0] dt64;

   assign busy   = 1'b0;
   assign accept = start & ~busy;
   assign vld_in = {vld_ff[Lat-2:0], accept};
   assign dt64   = 64'($signed({1'b0, time_step_ff}));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         time_step_ff <= TimeStepReset;
      end else begin
         vld_ff <= vld_in;
         if (csr_we) begin
            time_step_ff <= csr_wdata;
         end
      end
   end

   // unpack the request beat
   logic signed [31:0] in_p [3];
   logic signed [31:0] in_v [3];
   logic signed [31:0] in_e [3];
   logic signed [31:0] in_b [3];

   assign in_p[0] = req_data.pos_x;
   assign in_p[1] = req_data.pos_y;
   assign in_p[2] = req_data.pos_z;
   assign in_v[0] = req_data.vel_x;
   assign in_v[1] = req_data.vel_y;
   assign in_v[2] = req_data.vel_z;
   assign in_e[0] = req_data.efield_x;
   assign in_e[1] = req_data.efield_y;
   assign in_e[2] = req_data.efield_z;
   assign in_b[0] = req_data.bfield_x;
   assign in_b[1] = req_data.bfield_y;
   assign in_b[2] = req_data.bfield_z;

   // stage a: field and velocity times dt
   logic signed [31:0] a_p_ff [3], a_v_ff [3];
   logic signed [62:0] a_vdt_ff [3], a_edt_ff [3], a_bdt_ff [3];
   logic signed [62:0] a_vdt_in [3], a_edt_in [3], a_bdt_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_vdt_in[i] = 63'(smul(64'(in_v[i]), dt64));
         a_edt_in[i] = 63'(smul(64'(in_e[i]), dt64));
         a_bdt_in[i] = 63'(smul(64'(in_b[i]), dt64));
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         a_p_ff[i]   <= in_p[i];
         a_v_ff[i]   <= in_v[i];
         a_vdt_ff[i] <= a_vdt_in[i];
         a_edt_ff[i] <= a_edt_in[i];
         a_bdt_ff[i] <= a_bdt_in[i];
      end
   end

   // stage b: half drift, half kick, rotation vector t
   logic signed [31:0] b_p1_ff [3], b_vm_ff [3], b_t_ff [3];
   logic signed [31:0] b_p1_in [3], b_vm_in [3], b_t_in [3];
   logic signed [47:0] b_ek_ff [3], b_ek_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         b_p1_in[i] = sat32(64'(a_p_ff[i]) + 64'(rh(64'(a_vdt_ff[i]))));
         b_ek_in[i] = rh(64'(a_edt_ff[i]));
         b_vm_in[i] = sat32(64'(a_v_ff[i]) + 64'(b_ek_in[i]));
         b_t_in[i]  = sat32(64'(rh(64'(a_bdt_ff[i]))));
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         b_p1_ff[i] <= b_p1_in[i];
         b_ek_ff[i] <= b_ek_in[i];
         b_vm_ff[i] <= b_vm_in[i];
         b_t_ff[i]  <= b_t_in[i];
      end
   end

   // stage c: |t|^2 terms and first cross product terms
   logic signed [31:0] c_p1_ff [3], c_vm_ff [3], c_t_ff [3];
   logic signed [47:0] c_ek_ff [3];
   logic signed [63:0] c_tt_ff [3], c_xa_ff [3], c_xb_ff [3];
   logic signed [63:0] c_tt_in [3], c_xa_in [3], c_xb_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         c_tt_in[i] = smul(64'(b_t_ff[i]), 64'(b_t_ff[i]));
         c_xa_in[i] = smul(64'(b_vm_ff[(i+1)%3]), 64'(b_t_ff[(i+2)%3]));
         c_xb_in[i] = smul(64'(b_vm_ff[(i+2)%3]), 64'(b_t_ff[(i+1)%3]));
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         c_p1_ff[i] <= b_p1_ff[i];
         c_ek_ff[i] <= b_ek_ff[i];
         c_vm_ff[i] <= b_vm_ff[i];
         c_t_ff[i]  <= b_t_ff[i];
         c_tt_ff[i] <= c_tt_in[i];
         c_xa_ff[i] <= c_xa_in[i];
         c_xb_ff[i] <= c_xb_in[i];
      end
   end

   // stage d: squared norm of t, per-component |t|, first rotation half vq
   logic signed [31:0] d_p1_ff [3], d_vm_ff [3], d_vq_ff [3], d_vq_in [3];
   logic signed [47:0] d_ek_ff [3];
   logic [31:0]        d_tmag_ff [3], d_tmag_in [3];
   logic [2:0]         d_tneg_ff;
   logic [DenW-1:0]    d_nrm_ff, d_nrm_in;

   always_comb begin
      d_nrm_in = DenW'($unsigned(rm(c_tt_ff[0]))) + DenW'($unsigned(rm(c_tt_ff[1])))
               + DenW'($unsigned(rm(c_tt_ff[2])));
      for (int i = 0; i < 3; i++) begin
         d_vq_in[i]   = sat32(64'(c_vm_ff[i]) + 64'(rm(c_xa_ff[i])) - 64'(rm(c_xb_ff[i])));
         d_tmag_in[i] = c_t_ff[i][31] ? 32'(-c_t_ff[i]) : 32'(c_t_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      d_nrm_ff <= d_nrm_in;
      for (int i = 0; i < 3; i++) begin
         d_p1_ff[i]   <= c_p1_ff[i];
         d_ek_ff[i]   <= c_ek_ff[i];
         d_vm_ff[i]   <= c_vm_ff[i];
         d_vq_ff[i]   <= d_vq_in[i];
         d_tmag_ff[i] <= d_tmag_in[i];
         d_tneg_ff[i] <= c_t_ff[i][31];
      end
   end

   // stage e: divisor 1+|t|^2 and rounded numerators 2|t| + den/2
   logic [DenW-1:0] e_den_ff, e_den_in;
   logic [NumW-1:0] e_num_ff [3], e_num_in [3];
   side_type        e_side_ff, e_side_in;

   always_comb begin
      e_den_in = DenW'(65536) + d_nrm_ff;
      for (int i = 0; i < 3; i++) begin
         // den/2 is 2^15 + nrm/2 since 2^16 is even
         e_num_in[i] = (NumW'(d_tmag_ff[i]) << 17) + NumW'(32768) + NumW'(d_nrm_ff >> 1);
         e_side_in.vq[i]   = d_vq_ff[i];
         e_side_in.vm[i]   = d_vm_ff[i];
         e_side_in.p1[i]   = d_p1_ff[i];
         e_side_in.ek[i]   = d_ek_ff[i];
         e_side_in.tneg[i] = d_tneg_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      e_den_ff  <= e_den_in;
      e_side_ff <= e_side_in;
      for (int i = 0; i < 3; i++) begin
         e_num_ff[i] <= e_num_in[i];
      end
   end

   // rotation divider lanes and the matching delay line
   logic [QuoW-1:0] div_quo [3];
   side_type        side_ff [QuoW];

   for (genvar g = 0; g < 3; g++) begin : g_div
      bpp_div u_div (
         .clock (clock),
         .num   (e_num_ff[g]),
         .den   (e_den_ff),
         .quo   (div_quo[g])
      );
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= e_side_ff;
      for (int i = 1; i < QuoW; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
   end

   side_type q_side;
   assign q_side = side_ff[QuoW-1];

   // stage f: signed s and second cross product terms
   logic signed [QuoW:0]  f_s [3];
   logic signed [50:0]    f_xa_ff [3], f_xb_ff [3], f_xa_in [3], f_xb_in [3];
   logic signed [31:0]    f_vm_ff [3], f_p1_ff [3];
   logic signed [47:0]    f_ek_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         f_s[i] = q_side.tneg[i] ? -$signed({1'b0, div_quo[i]}) : $signed({1'b0, div_quo[i]});
      end
      for (int i = 0; i < 3; i++) begin
         f_xa_in[i] = 51'(smul(64'($signed(q_side.vq[(i+1)%3])), 64'(f_s[(i+2)%3])));
         f_xb_in[i] = 51'(smul(64'($signed(q_side.vq[(i+2)%3])), 64'(f_s[(i+1)%3])));
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         f_xa_ff[i] <= f_xa_in[i];
         f_xb_ff[i] <= f_xb_in[i];
         f_vm_ff[i] <= $signed(q_side.vm[i]);
         f_p1_ff[i] <= $signed(q_side.p1[i]);
         f_ek_ff[i] <= $signed(q_side.ek[i]);
      end
   end

   // stage g: rotated velocity vp
   logic signed [31:0] g_vp_ff [3], g_vp_in [3], g_p1_ff [3];
   logic signed [47:0] g_ek_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         g_vp_in[i] = sat32(64'(f_vm_ff[i]) + 64'(rm(64'(f_xa_ff[i])))
                            - 64'(rm(64'(f_xb_ff[i]))));
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         g_vp_ff[i] <= g_vp_in[i];
         g_p1_ff[i] <= f_p1_ff[i];
         g_ek_ff[i] <= f_ek_ff[i];
      end
   end

   // stage h: second half kick
   logic signed [31:0] h_vn_ff [3], h_vn_in [3], h_p1_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         h_vn_in[i] = sat32(64'(g_vp_ff[i]) + 64'(g_ek_ff[i]));
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         h_vn_ff[i] <= h_vn_in[i];
         h_p1_ff[i] <= g_p1_ff[i];
      end
   end

   // stage i: new velocity times dt
   logic signed [31:0] i_vn_ff [3], i_p1_ff [3];
   logic signed [62:0] i_vdt_ff [3], i_vdt_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         i_vdt_in[i] = 63'(smul(64'(h_vn_ff[i]), dt64));
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         i_vdt_ff[i] <= i_vdt_in[i];
         i_vn_ff[i]  <= h_vn_ff[i];
         i_p1_ff[i]  <= h_p1_ff[i];
      end
   end

   // stage j: final half drift into the result beat
   bpp_rsp_type rsp_ff, rsp_in;
   logic signed [31:0] j_pn [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         j_pn[i] = sat32(64'(i_p1_ff[i]) + 64'(rh(64'(i_vdt_ff[i]))));
      end
      rsp_in.new_pos_x = j_pn[0];
      rsp_in.new_pos_y = j_pn[1];
      rsp_in.new_pos_z = j_pn[2];
      rsp_in.new_vel_x = i_vn_ff[0];
      rsp_in.new_vel_y = i_vn_ff[1];
      rsp_in.new_vel_z = i_vn_ff[2];
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = vld_ff[Lat-1];

   // every accepted beat comes out as a result strobe at the end of the pipeline
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##Lat rsp_valid)
      else $error("result strobe missing after accepted beat");

   // no result without a matching accepted beat at the head of the pipeline
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, Lat))
      else $error("result strobe without accepted beat");

   // zero step passes the particle through unchanged, checked on vel_y and pos_z
   a_zero_dt_vel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && time_step_ff == '0) |-> rsp_data.new_vel_y == $past(req_data.vel_y, Lat))
      else $error("zero step changed velocity");

   a_zero_dt_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && time_step_ff == '0) |-> rsp_data.new_pos_z == $past(req_data.pos_z, Lat))
      else $error("zero step changed position");

endmodule
